### sv/haptic_knob_effect_controller_macros.svh
// ============================================================================
// Haptic knob effect controller assertion macros
// Shared property forms for the interface checker.
// ============================================================================
`ifndef HAPTIC_KNOB_EFFECT_CONTROLLER_MACROS_SVH
`define HAPTIC_KNOB_EFFECT_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define HKEC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define HKEC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/hkec_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// Haptic knob effect controller package
// Constants, register codes and shared types.
// ============================================================================
package hkec_pkg;

    localparam int unsigned RAW_W   = 14;
    localparam int unsigned ANGLE_W = 15;
    localparam int unsigned HALF_W  = 14;
    localparam int unsigned DUTY_W  = 16;
    localparam int unsigned GAIN_W  = 10;
    localparam int unsigned MODE_W  = 3;
    localparam int unsigned LED_W   = 3;
    localparam int unsigned PROD_W  = ANGLE_W + GAIN_W;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned S_TDATA_W  = 16;
    localparam int unsigned M_TDATA_W  = 56;

    localparam logic [RAW_W-1:0]   UNWRAP_LIMIT  = 14'd13000;
    localparam logic [ANGLE_W-1:0] UNWRAP_OFFSET = 15'd16398;
    localparam logic [DUTY_W-1:0]  DUTY_MAX      = 16'hFFFF;

    localparam logic [MODE_W-1:0] MODE_NONE    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SPRING  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_WALL    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TEXTURE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DAMPER  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_EFFECT_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_ANGLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_HALF    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WALL_ANGLE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_BASE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPRING_GAIN  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TEXTURE_GAIN = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPER_GAIN  = 3'd7;

    localparam logic [ANGLE_W-1:0] RST_CENTER_ANGLE = 15'd20000;
    localparam logic [HALF_W-1:0]  RST_BAND_HALF    = 14'd2000;
    localparam logic [ANGLE_W-1:0] RST_WALL_ANGLE   = 15'd22000;
    localparam logic [DUTY_W-1:0]  RST_DUTY_BASE    = 16'h3000;
    localparam logic [GAIN_W-1:0]  RST_SPRING_GAIN  = 10'd20;
    localparam logic [GAIN_W-1:0]  RST_TEXTURE_GAIN = 10'd500;
    localparam logic [GAIN_W-1:0]  RST_DAMPER_GAIN  = 10'd400;

    typedef struct packed {
        logic [MODE_W-1:0]  effect_mode;
        logic [ANGLE_W-1:0] center_angle;
        logic [HALF_W-1:0]  band_half_width;
        logic [ANGLE_W-1:0] wall_angle;
        logic [DUTY_W-1:0]  duty_base;
        logic [GAIN_W-1:0]  spring_gain;
        logic [GAIN_W-1:0]  texture_gain;
        logic [GAIN_W-1:0]  damper_gain;
    } t_cfg;

    // leds: bit 0 LED one, bit 1 LED two, bit 2 LED three
    typedef struct packed {
        logic [ANGLE_W-1:0] last_angle;
        logic [DUTY_W-1:0]  velocity;
        logic [DUTY_W-1:0]  forward_duty;
        logic [DUTY_W-1:0]  backward_duty;
        logic [LED_W-1:0]   leds;
    } t_state;

endpackage

### sv/hkec_effect_core.sv
`timescale 1ns / 1ps
// ============================================================================
// Haptic knob effect core
// Angle unwrap and effect update for one request, purely combinational.
// ============================================================================
module hkec_effect_core
    import hkec_pkg::*;
(
    input  t_cfg               i_cfg,
    input  t_state             i_state,
    input  logic [RAW_W-1:0]   i_raw_angle,
    input  logic               i_period_tick,
    output t_state             o_state,
    output logic [ANGLE_W-1:0] o_unwrapped_angle
);

    logic [ANGLE_W-1:0] w_angle;
    logic [DUTY_W-1:0]  w_band_hi;
    logic [DUTY_W-1:0]  w_angle_plus_h;
    logic               w_above;
    logic               w_below;
    logic [ANGLE_W-1:0] w_diff;
    logic [DUTY_W-1:0]  w_vel;
    logic               w_damper;
    logic               w_band_mode;
    logic [ANGLE_W-1:0] w_mul_a;
    logic [GAIN_W-1:0]  w_mul_b;
    logic [PROD_W-1:0]  w_prod;
    logic [PROD_W:0]    w_sum;
    logic [DUTY_W-1:0]  w_sat;

    assign w_angle = (i_raw_angle < UNWRAP_LIMIT)
                   ? ANGLE_W'(i_raw_angle) + UNWRAP_OFFSET
                   : ANGLE_W'(i_raw_angle);
    assign o_unwrapped_angle = w_angle;

    assign w_band_hi      = {1'b0, i_cfg.center_angle} + {2'b00, i_cfg.band_half_width};
    assign w_angle_plus_h = {1'b0, w_angle} + {2'b00, i_cfg.band_half_width};
    assign w_above = (w_angle > i_cfg.center_angle) && ({1'b0, w_angle} < w_band_hi);
    assign w_below = (w_angle < i_cfg.center_angle)
                  && (w_angle_plus_h > {1'b0, i_cfg.center_angle});
    assign w_diff  = (w_angle > i_cfg.center_angle) ? w_angle - i_cfg.center_angle
                                                     : i_cfg.center_angle - w_angle;

    assign w_vel = i_period_tick ? ({1'b0, w_angle} - {1'b0, i_state.last_angle})
                                 : i_state.velocity;

    assign w_damper    = (i_cfg.effect_mode == MODE_DAMPER);
    assign w_band_mode = !w_damper;
    assign w_mul_a     = w_damper ? w_vel[ANGLE_W-1:0] : w_diff;
    assign w_mul_b     = w_damper ? i_cfg.damper_gain
                       : ((i_cfg.effect_mode == MODE_TEXTURE) ? i_cfg.texture_gain
                                                              : i_cfg.spring_gain);
    assign w_prod = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);
    assign w_sum  = {1'b0, w_prod}
                  + (w_band_mode ? (PROD_W+1)'(i_cfg.duty_base) : '0);
    assign w_sat  = (|w_sum[PROD_W:DUTY_W]) ? DUTY_MAX : w_sum[DUTY_W-1:0];

    always_comb begin
        o_state = i_state;
        case (i_cfg.effect_mode)
            MODE_SPRING, MODE_TEXTURE: begin
                if (w_above) begin
                    o_state.forward_duty  = '0;
                    o_state.backward_duty = w_sat;
                    o_state.leds[0]       = 1'b1;
                end else if (w_below) begin
                    o_state.forward_duty  = w_sat;
                    o_state.backward_duty = '0;
                    o_state.leds[1]       = 1'b1;
                end else begin
                    o_state.forward_duty  = '0;
                    o_state.backward_duty = '0;
                    o_state.leds[1:0]     = 2'b00;
                end
            end
            MODE_WALL: begin
                if (w_angle > i_cfg.wall_angle && i_state.last_angle < i_cfg.wall_angle) begin
                    o_state.leds[1:0]     = 2'b01;
                    o_state.backward_duty = '0;
                    o_state.forward_duty  = DUTY_MAX;
                end else if (w_angle < i_cfg.wall_angle
                             && i_state.last_angle > i_cfg.wall_angle) begin
                    o_state.forward_duty = '0;
                    o_state.leds[1:0]    = 2'b10;
                end
                o_state.last_angle = w_angle;
            end
            MODE_DAMPER: begin
                o_state.velocity = w_vel;
                if (i_period_tick) begin
                    o_state.last_angle = w_angle;
                end
                if (w_vel[DUTY_W-1]) begin
                    o_state.forward_duty  = '0;
                    o_state.backward_duty = '0;
                    o_state.leds          = 3'b010;
                end else if (w_vel != '0) begin
                    o_state.backward_duty = w_sat;
                    o_state.forward_duty  = '0;
                    o_state.leds          = 3'b001;
                end else begin
                    o_state.leds = 3'b000;
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

### sv/haptic_knob_effect_controller.sv
`timescale 1ns / 1ps
// ============================================================================
// Haptic knob effect controller
// Spring, wall, texture and damper effects on an unwrapped encoder angle.
// ============================================================================
// One request per clock is taken while the output is not stalled. The request
// lands in an input register, and from there the effect core (one 15x10
// multiplier, a saturating add and the band compares) loads the result register
// when the output is free; that register also holds the duties, LEDs and damper
// history, and the result is presented from it.
// While a result waits on the output, one more request is taken into the
// input register and then the input stalls.
// Configuration writes are always ready and are meant for an idle block.
module haptic_knob_effect_controller
    import hkec_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,   // [13:0] raw_angle, rest zero
    input  logic                  i_s_tuser,   // [0] period_tick
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [15:0] forward_duty, [31:16] backward_duty, [32] led_one, [33] led_two,
    // [34] led_three, [49:35] unwrapped_angle, rest zero
    output logic [M_TDATA_W-1:0]  o_m_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg               r_cfg;
    logic               r_in_valid;
    logic [RAW_W-1:0]   r_raw_angle;
    logic               r_tick;
    logic               r_out_valid;
    t_state             r_state;
    logic [ANGLE_W-1:0] r_unwrapped;

    t_state             n_state;
    logic [ANGLE_W-1:0] n_unwrapped;
    logic               w_advance;
    logic               w_s_accept;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.effect_mode     <= MODE_NONE;
            r_cfg.center_angle    <= RST_CENTER_ANGLE;
            r_cfg.band_half_width <= RST_BAND_HALF;
            r_cfg.wall_angle      <= RST_WALL_ANGLE;
            r_cfg.duty_base       <= RST_DUTY_BASE;
            r_cfg.spring_gain     <= RST_SPRING_GAIN;
            r_cfg.texture_gain    <= RST_TEXTURE_GAIN;
            r_cfg.damper_gain     <= RST_DAMPER_GAIN;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_EFFECT_MODE:  r_cfg.effect_mode     <= i_cfg_wdata[MODE_W-1:0];
                REG_CENTER_ANGLE: r_cfg.center_angle    <= i_cfg_wdata[ANGLE_W-1:0];
                REG_BAND_HALF:    r_cfg.band_half_width <= i_cfg_wdata[HALF_W-1:0];
                REG_WALL_ANGLE:   r_cfg.wall_angle      <= i_cfg_wdata[ANGLE_W-1:0];
                REG_DUTY_BASE:    r_cfg.duty_base       <= i_cfg_wdata[DUTY_W-1:0];
                REG_SPRING_GAIN:  r_cfg.spring_gain     <= i_cfg_wdata[GAIN_W-1:0];
                REG_TEXTURE_GAIN: r_cfg.texture_gain    <= i_cfg_wdata[GAIN_W-1:0];
                REG_DAMPER_GAIN:  r_cfg.damper_gain     <= i_cfg_wdata[GAIN_W-1:0];
                default:          r_cfg                 <= r_cfg;
            endcase
        end
    end

    assign w_advance  = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_advance;
    assign w_s_accept = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_s_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // hold the request until the core has taken it
    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_raw_angle <= i_s_tdata[RAW_W-1:0];
            r_tick      <= i_s_tuser;
        end
    end

    hkec_effect_core u_core (
        .i_cfg             (r_cfg),
        .i_state           (r_state),
        .i_raw_angle       (r_raw_angle),
        .i_period_tick     (r_tick),
        .o_state           (n_state),
        .o_unwrapped_angle (n_unwrapped)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_unwrapped <= n_unwrapped;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'b000000, r_unwrapped, r_state.leds,
                         r_state.backward_duty, r_state.forward_duty};

endmodule

### sv/hkec_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// Haptic knob effect controller checker
// Port-level properties, bound to the top level.
// ============================================================================
`include "haptic_knob_effect_controller_macros.svh"

module hkec_checker
    import hkec_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  o_s_tready,
    input  logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [M_TDATA_W-1:0]  o_m_tdata
);

    `HKEC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready,
        o_m_tvalid && $stable(o_m_tdata), "result changed while stalled")

    `HKEC_ASSERT_SAME(a_ready_only_on_stall, i_clk, i_rst_n, !o_s_tready,
        o_m_tvalid && !i_m_tready, "input stalled without output back-pressure")

    `HKEC_ASSERT_SAME(a_one_drive_side, i_clk, i_rst_n, o_m_tvalid,
        o_m_tdata[15:0] == 16'h0000 || o_m_tdata[31:16] == 16'h0000,
        "both drive duties non-zero")

    `HKEC_ASSERT_SAME(a_unwrap_range, i_clk, i_rst_n, o_m_tvalid,
        (o_m_tdata[49:35] >= 15'd13000 && o_m_tdata[49:35] <= 15'd16383)
        || (o_m_tdata[49:35] >= 15'd16398 && o_m_tdata[49:35] <= 15'd29397),
        "unwrapped angle out of range")

endmodule

bind haptic_knob_effect_controller hkec_checker u_hkec_checker (.*);

### verif/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// Haptic knob effect controller testbench
// Drives encoder requests through the stream input under random back-pressure,
// predicts the duties, LEDs and unwrapped angle with its own effect model, and
// compares every result field in order. Directed requests cover the unwrap
// edges, band edges, saturation, wall crossings and damper velocity signs;
// random phases follow, each with a fresh register setting.
// ============================================================================
module tb_top;
    import hkec_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE = 3'd7;

    typedef struct {
        logic [DUTY_W-1:0]  forward_duty;
        logic [DUTY_W-1:0]  backward_duty;
        logic               led_one;
        logic               led_two;
        logic               led_three;
        logic [ANGLE_W-1:0] unwrapped_angle;
    } t_drive;

    class knob_effect_tracker;
        t_cfg   regs;
        t_state st;
        t_drive expected_drives[$];
        int     errors;

        function new();
            regs.effect_mode     = MODE_NONE;
            regs.center_angle    = RST_CENTER_ANGLE;
            regs.band_half_width = RST_BAND_HALF;
            regs.wall_angle      = RST_WALL_ANGLE;
            regs.duty_base       = RST_DUTY_BASE;
            regs.spring_gain     = RST_SPRING_GAIN;
            regs.texture_gain    = RST_TEXTURE_GAIN;
            regs.damper_gain     = RST_DAMPER_GAIN;
            st     = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                REG_EFFECT_MODE:  regs.effect_mode     = d[MODE_W-1:0];
                REG_CENTER_ANGLE: regs.center_angle    = d[ANGLE_W-1:0];
                REG_BAND_HALF:    regs.band_half_width = d[HALF_W-1:0];
                REG_WALL_ANGLE:   regs.wall_angle      = d[ANGLE_W-1:0];
                REG_DUTY_BASE:    regs.duty_base       = d[DUTY_W-1:0];
                REG_SPRING_GAIN:  regs.spring_gain     = d[GAIN_W-1:0];
                REG_TEXTURE_GAIN: regs.texture_gain    = d[GAIN_W-1:0];
                REG_DAMPER_GAIN:  regs.damper_gain     = d[GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [DUTY_W-1:0] clamp_duty(longint v);
            return (v > 65535) ? DUTY_MAX : v[DUTY_W-1:0];
        endfunction

        function void band_push(int a, int gain);
            int     c;
            int     h;
            longint base;
            c    = int'(regs.center_angle);
            h    = int'(regs.band_half_width);
            base = longint'(regs.duty_base);
            if (a > c && a < c + h) begin
                st.forward_duty  = '0;
                st.backward_duty = clamp_duty(longint'(a - c) * gain + base);
                st.leds[0]       = 1'b1;
            end else if (a > c - h && a < c) begin
                st.leds[1]       = 1'b1;
                st.backward_duty = '0;
                st.forward_duty  = clamp_duty(longint'(c - a) * gain + base);
            end else begin
                st.forward_duty  = '0;
                st.backward_duty = '0;
                st.leds[1:0]     = 2'b00;
            end
        endfunction

        function void note_request(logic [RAW_W-1:0] raw, logic tick);
            logic [ANGLE_W-1:0] a;
            int                 v;
            t_drive             d;
            a = (raw < UNWRAP_LIMIT) ? {1'b0, raw} + UNWRAP_OFFSET : {1'b0, raw};
            case (regs.effect_mode)
                MODE_SPRING:  band_push(int'(a), int'(regs.spring_gain));
                MODE_TEXTURE: band_push(int'(a), int'(regs.texture_gain));
                MODE_WALL: begin
                    if (a > regs.wall_angle && st.last_angle < regs.wall_angle) begin
                        st.leds[0]       = 1'b1;
                        st.leds[1]       = 1'b0;
                        st.backward_duty = '0;
                        st.forward_duty  = DUTY_MAX;
                    end else if (a < regs.wall_angle && st.last_angle > regs.wall_angle) begin
                        st.forward_duty = '0;
                        st.leds[1]      = 1'b1;
                        st.leds[0]      = 1'b0;
                    end
                    st.last_angle = a;
                end
                MODE_DAMPER: begin
                    if (tick) begin
                        st.velocity   = {1'b0, a} - {1'b0, st.last_angle};
                        st.last_angle = a;
                    end
                    v = int'($signed(st.velocity));
                    if (v < 0) begin
                        st.forward_duty  = '0;
                        st.backward_duty = '0;
                        st.leds          = 3'b010;
                    end else if (v > 0) begin
                        st.backward_duty = clamp_duty(longint'(v) * longint'(regs.damper_gain));
                        st.forward_duty  = '0;
                        st.leds          = 3'b001;
                    end else begin
                        st.leds = 3'b000;
                    end
                end
                default: ;
            endcase
            d.forward_duty    = st.forward_duty;
            d.backward_duty   = st.backward_duty;
            d.led_one         = st.leds[0];
            d.led_two         = st.leds[1];
            d.led_three       = st.leds[2];
            d.unwrapped_angle = a;
            expected_drives.push_back(d);
        endfunction

        function void match(string name, logic [DUTY_W-1:0] want, logic [DUTY_W-1:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] tdata);
            t_drive d;
            if (expected_drives.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
                return;
            end
            d = expected_drives.pop_front();
            match("forward_duty", d.forward_duty, tdata[15:0]);
            match("backward_duty", d.backward_duty, tdata[31:16]);
            match("led_one", DUTY_W'(d.led_one), DUTY_W'(tdata[32]));
            match("led_two", DUTY_W'(d.led_two), DUTY_W'(tdata[33]));
            match("led_three", DUTY_W'(d.led_three), DUTY_W'(tdata[34]));
            match("unwrapped_angle", DUTY_W'(d.unwrapped_angle), DUTY_W'(tdata[49:35]));
        endfunction

        function int outstanding();
            return expected_drives.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata;
    logic                  i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    knob_effect_tracker tracker = new();
    bit src_calm;
    bit sink_calm;
    bit hold_req;
    int drift;

    haptic_knob_effect_controller u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic int pick_gap(bit calm);
        if (calm || $urandom_range(0, 3) != 0) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [RAW_W-1:0] raw_for(int a);
        int top;
        top = int'(UNWRAP_OFFSET) + int'(UNWRAP_LIMIT) - 1;
        if (a < int'(UNWRAP_LIMIT)) a = int'(UNWRAP_LIMIT);
        if (a > top) a = top;
        if (a < (1 << RAW_W)) return a[RAW_W-1:0];
        if (a < int'(UNWRAP_OFFSET)) a = int'(UNWRAP_OFFSET);
        return RAW_W'(a - int'(UNWRAP_OFFSET));
    endfunction

    function automatic logic [RAW_W-1:0] pick_raw(logic [MODE_W-1:0] mode);
        int a;
        int r;
        int c;
        int h;
        int w;
        r = $urandom_range(0, 99);
        c = int'(tracker.regs.center_angle);
        h = int'(tracker.regs.band_half_width);
        w = int'(tracker.regs.wall_angle);
        if (r < 15) return RAW_W'($urandom_range(0, (1 << RAW_W) - 1));
        case (mode)
            MODE_SPRING, MODE_TEXTURE: begin
                if (r < 30)
                    a = c + int'($urandom_range(0, 2)) - 1;
                else if (r < 40)
                    a = c + ((r % 2) ? h : -h) + int'($urandom_range(0, 2)) - 1;
                else
                    a = c + int'($urandom_range(0, 2 * (h + 4))) - (h + 4);
            end
            MODE_WALL: a = w + int'($urandom_range(0, 80)) - 40;
            MODE_DAMPER: begin
                if (r < 20)
                    drift = $urandom_range(13000, 29397);
                else
                    drift = drift + int'($urandom_range(0, 600)) - 300;
                drift = (drift < 13000) ? 13000 : (drift > 29397) ? 29397 : drift;
                a = drift;
            end
            default: a = $urandom_range(13000, 29397);
        endcase
        return raw_for(a);
    endfunction

    function automatic int pick_span(int hi);
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return 0;
        if (r == 1) return hi;
        return $urandom_range(0, hi);
    endfunction

    function automatic int pick_position();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 0;
        if (r == 1) return (1 << ANGLE_W) - 1;
        return $urandom_range(13000, 29397);
    endfunction

    function automatic t_cfg random_cfg();
        t_cfg c;
        int   r;
        case ($urandom_range(0, 5))
            0:       c.effect_mode = MODE_SPRING;
            1:       c.effect_mode = MODE_WALL;
            2:       c.effect_mode = MODE_TEXTURE;
            3:       c.effect_mode = MODE_DAMPER;
            default: c.effect_mode = MODE_W'($urandom_range(0, (1 << MODE_W) - 1));
        endcase
        c.center_angle = ANGLE_W'(pick_position());
        c.wall_angle   = ANGLE_W'(pick_position());
        r = $urandom_range(0, 7);
        c.band_half_width = HALF_W'((r == 0) ? 0 : (r == 1) ? (1 << HALF_W) - 1
                                                            : int'($urandom_range(0, 3000)));
        c.duty_base    = DUTY_W'(pick_span((1 << DUTY_W) - 1));
        c.spring_gain  = GAIN_W'(pick_span((1 << GAIN_W) - 1));
        c.texture_gain = GAIN_W'(pick_span((1 << GAIN_W) - 1));
        c.damper_gain  = GAIN_W'(pick_span((1 << GAIN_W) - 1));
        return c;
    endfunction

    task automatic send_item(input logic [RAW_W-1:0] raw, input logic tick);
        int gap;
        gap = pick_gap(src_calm);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(S_TDATA_W - RAW_W){1'b0}}, raw};
        i_s_tuser  <= tick;
        do @(posedge i_clk); while (!o_s_tready);
        tracker.note_request(raw, tick);
    endtask

    // drop the request line and hold until every result is back
    task automatic pause_stream();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tracker.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value, input int width);
        logic [CFG_DATA_W-1:0] d;
        d = value;
        if (width < CFG_DATA_W && $urandom_range(0, 1)) d = d | (16'($urandom) << width);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.write_reg(idx, d);
    endtask

    task automatic load_cfg(input t_cfg c);
        pause_stream();
        cfg_write(REG_EFFECT_MODE, CFG_DATA_W'(c.effect_mode), MODE_W);
        cfg_write(REG_CENTER_ANGLE, CFG_DATA_W'(c.center_angle), ANGLE_W);
        cfg_write(REG_BAND_HALF, CFG_DATA_W'(c.band_half_width), HALF_W);
        cfg_write(REG_WALL_ANGLE, CFG_DATA_W'(c.wall_angle), ANGLE_W);
        cfg_write(REG_DUTY_BASE, c.duty_base, DUTY_W);
        cfg_write(REG_SPRING_GAIN, CFG_DATA_W'(c.spring_gain), GAIN_W);
        cfg_write(REG_TEXTURE_GAIN, CFG_DATA_W'(c.texture_gain), GAIN_W);
        cfg_write(REG_DAMPER_GAIN, CFG_DATA_W'(c.damper_gain), GAIN_W);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int wait_left;
        i_m_tready = 1'b0;
        wait_left  = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) tracker.check_result(o_m_tdata);
            if (hold_req) begin
                hold_req  = 1'b0;
                wait_left = 300;
            end else if (wait_left == 0) begin
                wait_left = pick_gap(sink_calm);
            end
            if (wait_left > 0) begin
                i_m_tready <= 1'b0;
                wait_left--;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    initial begin
        t_cfg c;
        int   n;
        int   sent;
        int   phase;
        int   band_pts[7] = '{20000, 20001, 21999, 22000, 18000, 18001, 19999};
        int   wall_pts[6] = '{21000, 23000, 22000, 21000, 23000, 21000};
        int   damp_pts[5] = '{23000, 23000, 20000, 20000, 20050};
        bit   damp_tick[5] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        src_calm    = 1'b0;
        sink_calm   = 1'b0;
        hold_req    = 1'b0;
        drift       = 20000;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(14'd0, 1'b1);
        send_item(14'd12999, 1'b0);
        send_item(14'd13000, 1'b1);
        send_item(14'd16383, 1'b0);

        c = tracker.regs;
        c.effect_mode = MODE_SPRING;
        load_cfg(c);
        foreach (band_pts[i]) send_item(raw_for(band_pts[i]), i[0]);

        c.effect_mode  = MODE_TEXTURE;
        c.duty_base    = DUTY_MAX;
        c.texture_gain = '1;
        load_cfg(c);
        send_item(raw_for(21000), 1'b0);
        send_item(raw_for(19000), 1'b1);

        c.effect_mode = MODE_WALL;
        load_cfg(c);
        foreach (wall_pts[i]) send_item(raw_for(wall_pts[i]), 1'b0);

        c.effect_mode = MODE_DAMPER;
        load_cfg(c);
        foreach (damp_pts[i]) send_item(raw_for(damp_pts[i]), damp_tick[i]);

        c.effect_mode = MODE_SPARE;
        load_cfg(c);
        send_item(raw_for(25000), 1'b1);

        sent  = 0;
        phase = 0;
        while (sent < 1425) begin
            c = random_cfg();
            src_calm  = ($urandom_range(0, 4) == 0);
            sink_calm = ($urandom_range(0, 4) == 0);
            load_cfg(c);
            n = $urandom_range(40, 110);
            // stall the result side for a long stretch while requests keep coming
            if (phase == 2) begin
                src_calm  = 1'b1;
                sink_calm = 1'b0;
                hold_req  = 1'b1;
            end
            for (int k = 0; k < n; k++) begin
                if (k == n / 2 && $urandom_range(0, 3) == 0) pause_stream();
                send_item(pick_raw(c.effect_mode), 1'($urandom_range(0, 1)));
            end
            sent += n;
            phase++;
        end

        pause_stream();
        repeat (10) @(posedge i_clk);
        if (tracker.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

### filelist.f
+incdir+sv
sv/hkec_pkg.sv
sv/hkec_effect_core.sv
sv/haptic_knob_effect_controller.sv
sv/hkec_checker.sv
verif/tb_top.sv
